// File: hw/rtl/b64_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types and constants of the streaming base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

   localparam int unsigned QueueDepth   = 2;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [CsrAddrWidth-3:0] ModeIndex = '0;

   localparam logic [7:0] PadChar   = 8'h3D;
   localparam logic [7:0] PlusChar  = 8'h2B;
   localparam logic [7:0] SlashChar = 8'h2F;
   localparam logic [7:0] BadCode   = 8'hFF;

   localparam logic ModeEncode = 1'b0;
   localparam logic ModeDecode = 1'b1;

   localparam logic CmdData  = 1'b0;
   localparam logic CmdFlush = 1'b1;

   // one group of results: up to four bytes, emitted index 0 first
   typedef struct packed {
      logic [3:0][7:0] value;
      logic [1:0]      last_idx;
      logic            is_error;
   } job_type;

endpackage
`default_nettype wire

// File: hw/rtl/b64_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64_front
// Accepts requests, tracks the group state and builds one result job per
// completed group, per flush of a partial group, or per error.
// ----------------------------------------------------------------------------
module b64_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            mode,
   input  wire logic            mode_write,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic            req_command,
   input  wire logic [7:0]      req_data_value,
   input  wire logic            push_ready,
   output logic                 push_valid,
   output b64_pkg::job_type     push_job
);

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         r = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         r = b64_pkg::PlusChar;
      end else begin
         r = b64_pkg::SlashChar;
      end
      return r;
   endfunction

   function automatic logic [7:0] char_sextet(input logic [7:0] c);
      logic [7:0] r;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = c - 8'h30 + 8'd52;
      end else if (c == b64_pkg::PlusChar) begin
         r = 8'd62;
      end else if (c == b64_pkg::SlashChar) begin
         r = 8'd63;
      end else begin
         r = b64_pkg::BadCode;
      end
      return r;
   endfunction

   logic [17:0] held_ff, held_in;
   logic [1:0]  pos_ff, pos_in;
   logic        tpad_ff, tpad_in;
   logic        err_ff, err_in;

   logic             accept;
   logic             emit;
   b64_pkg::job_type job;
   logic [23:0]      w;
   logic [7:0]       sx;
   logic             not_alpha;
   logic             is_pad;
   logic             bad;
   logic [5:0]       s_eff;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   assign sx        = char_sextet(req_data_value);
   assign not_alpha = (sx == b64_pkg::BadCode);
   assign is_pad    = (req_data_value == b64_pkg::PadChar);
   assign s_eff     = not_alpha ? 6'd0 : sx[5:0];
   assign bad       = not_alpha ? !(is_pad && (pos_ff == 2'd2 || pos_ff == 2'd3))
                                : (pos_ff == 2'd3 && tpad_ff);

   always_comb begin
      held_in  = held_ff;
      pos_in   = pos_ff;
      tpad_in  = tpad_ff;
      err_in   = err_ff;
      emit     = 1'b0;
      w        = '0;
      job      = '0;
      if (mode == b64_pkg::ModeEncode) begin
         if (req_command == b64_pkg::CmdData) begin
            w = {held_ff[15:0], req_data_value};
            if (pos_ff == 2'd2) begin
               emit           = 1'b1;
               job.value[0]   = sextet_char(w[23:18]);
               job.value[1]   = sextet_char(w[17:12]);
               job.value[2]   = sextet_char(w[11:6]);
               job.value[3]   = sextet_char(w[5:0]);
               job.last_idx   = 2'd3;
               held_in        = '0;
               pos_in         = '0;
               tpad_in        = 1'b0;
            end else begin
               held_in = w[17:0];
               pos_in  = pos_ff + 2'd1;
            end
         end else if (pos_ff != 2'd0) begin
            w              = (pos_ff == 2'd1) ? {held_ff[7:0], 16'h0000}
                                              : {held_ff[15:0], 8'h00};
            emit           = 1'b1;
            job.value[0]   = sextet_char(w[23:18]);
            job.value[1]   = sextet_char(w[17:12]);
            job.value[2]   = (pos_ff == 2'd2) ? sextet_char(w[11:6]) : b64_pkg::PadChar;
            job.value[3]   = b64_pkg::PadChar;
            job.last_idx   = 2'd3;
            held_in        = '0;
            pos_in         = '0;
            tpad_in        = 1'b0;
         end
      end else if (!err_ff) begin
         if (req_command == b64_pkg::CmdFlush) begin
            if (pos_ff != 2'd0) begin
               emit         = 1'b1;
               job.is_error = 1'b1;
               held_in      = '0;
               pos_in       = '0;
               tpad_in      = 1'b0;
            end
         end else if (bad) begin
            emit         = 1'b1;
            job.is_error = 1'b1;
            held_in      = '0;
            pos_in       = '0;
            tpad_in      = 1'b0;
            err_in       = 1'b1;
         end else begin
            w = {held_ff, s_eff};
            if (pos_ff == 2'd3) begin
               emit         = 1'b1;
               job.value[0] = w[23:16];
               job.value[1] = w[15:8];
               job.value[2] = w[7:0];
               if (tpad_ff) begin
                  job.last_idx = 2'd0;
               end else if (is_pad) begin
                  job.last_idx = 2'd1;
               end else begin
                  job.last_idx = 2'd2;
               end
               held_in = '0;
               pos_in  = '0;
               tpad_in = 1'b0;
            end else begin
               held_in = w[17:0];
               pos_in  = pos_ff + 2'd1;
               tpad_in = tpad_ff || (is_pad && pos_ff == 2'd2);
            end
         end
      end
   end

   assign push_valid = accept && emit;
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset || mode_write) begin
         held_ff <= '0;
         pos_ff  <= '0;
         tpad_ff <= 1'b0;
         err_ff  <= 1'b0;
      end else if (accept) begin
         held_ff <= held_in;
         pos_ff  <= pos_in;
         tpad_ff <= tpad_in;
         err_ff  <= err_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/b64_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64_queue
// Small job queue between the front and the back end.
// ----------------------------------------------------------------------------
module b64_queue #(
   parameter int unsigned Depth = b64_pkg::QueueDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire b64_pkg::job_type  push_job,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output b64_pkg::job_type       pop_job
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt  = CntWidth'(Depth);

   b64_pkg::job_type    mem [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0] count_ff;
   logic                push, pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntWidth'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntWidth'(1);
         end
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue count beyond depth");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (count_ff == '0) && (wr_ptr_ff == rd_ptr_ff))
      else $error("queue not empty after reset");

   a_fill_ptr: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FullCnt) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// File: hw/rtl/b64_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64_back
// Takes queued jobs, hands out results one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module b64_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire b64_pkg::job_type  pop_job,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_value,
   output logic                   rsp_is_error,
   output logic                   rsp_last
);

   b64_pkg::job_type cur_ff;
   logic [1:0]       idx_ff;
   logic             busy_ff;
   logic             at_last;

   assign at_last       = (idx_ff == cur_ff.last_idx);
   assign pop_ready     = !busy_ff || (rsp_ready && at_last);
   assign rsp_valid     = busy_ff;
   assign rsp_out_value = cur_ff.value[idx_ff];
   assign rsp_is_error  = cur_ff.is_error;
   assign rsp_last      = at_last;

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         cur_ff <= pop_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (pop_valid && pop_ready) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_ready) begin
         if (at_last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/base64_stream_codec_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// Streaming base64 codec, standard alphabet with '=' padding.
//
// Requests enter on req_* (valid/ready): command 0 carries a byte (encode)
// or a character (decode), command 1 flushes the stream. Results leave on
// rsp_* (valid/ready), one per cycle while rsp_ready is high, with rsp_last
// on the final result of a request. The mode register (csr_*, address 0)
// selects encode (0) or decode (1); any write to it clears the group state
// and the error latch. A request that completes a group has its job written
// into the job queue and then loaded into the back end's result register
// before rsp_valid rises for its first result. The front takes one request
// per cycle while the job queue has room; the back end emits one result per
// cycle while rsp_ready is high, so a request stream runs at up to one per
// cycle, and encoding's four characters per three bytes bound encode input.
// Reset clears the mode to encode, empties the queue and drops any result
// in flight. When the receiver stalls, the current result holds, the queue
// fills, and req_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module base64_stream_codec_top #(
   parameter int unsigned QueueDepth = b64_pkg::QueueDepth
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_command,
   input  wire logic [7:0]                         req_data_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [7:0]                              rsp_out_value,
   output logic                                    rsp_is_error,
   output logic                                    rsp_last,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [b64_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  wire logic [b64_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [b64_pkg::CsrDataWidth-1:0]        csr_prdata,
   output logic                                    csr_pready
);

   logic             mode_ff;
   logic             mode_write;
   logic             push_valid, push_ready;
   logic             pop_valid, pop_ready;
   b64_pkg::job_type push_job, pop_job;

   assign csr_pready = 1'b1;
   assign mode_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[b64_pkg::CsrAddrWidth-1:2] == b64_pkg::ModeIndex);
   assign csr_prdata = (csr_paddr[b64_pkg::CsrAddrWidth-1:2] == b64_pkg::ModeIndex)
                       ? {{(b64_pkg::CsrDataWidth-1){1'b0}}, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= b64_pkg::ModeEncode;
      end else if (mode_write) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   b64_front u_front (
      .clock          (clock),
      .reset          (reset),
      .mode           (mode_ff),
      .mode_write     (mode_write),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_data_value (req_data_value),
      .push_ready     (push_ready),
      .push_valid     (push_valid),
      .push_job       (push_job)
   );

   b64_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   b64_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_job       (pop_job),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_value (rsp_out_value),
      .rsp_is_error  (rsp_is_error),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire
